@@ src/sus_pkg.sv @@
package sus_pkg;

	localparam int MAX_SPHERES = 64;
	localparam int ADDR_W      = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
	localparam int COORD_W     = 24;
	localparam int RAD_W       = 23;
	localparam int DIST_W      = 26;
	localparam int ABS_W       = COORD_W + 1;
	localparam int SQ_W        = 2 * ABS_W;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int T_W         = 28;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [RAD_W-1:0]          r;
	} sphere_t;

	typedef struct packed {
		logic             last;
		logic [RAD_W-1:0] radius;
	} tag_t;

endpackage

@@ src/sus_store.sv @@
module sus_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [sus_pkg::ADDR_W-1:0] waddr,
	input  sus_pkg::sphere_t          wdata,
	input  logic [sus_pkg::ADDR_W-1:0] raddr,
	output sus_pkg::sphere_t          rdata
);

	sus_pkg::sphere_t mem [0:sus_pkg::MAX_SPHERES-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/sus_isqrt.sv @@
module sus_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [sus_pkg::SQ_W-1:0]   in_sq,
	input  sus_pkg::tag_t              in_tag,
	output logic                       out_vld,
	output logic [sus_pkg::ROOT_W-1:0] out_root,
	output sus_pkg::tag_t              out_tag
);

	localparam int N = sus_pkg::ROOT_W;

	logic                       vld_s  [0:N];
	logic [sus_pkg::SQ_W-1:0]   v_s    [0:N];
	logic [sus_pkg::REM_W-1:0]  rem_s  [0:N];
	logic [sus_pkg::ROOT_W-1:0] root_s [0:N];
	sus_pkg::tag_t              tag_s  [0:N];

	assign vld_s[0]  = in_vld;
	assign v_s[0]    = in_sq;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [sus_pkg::REM_W+1:0] acc;
		logic [sus_pkg::REM_W+1:0] trial;
		logic                      take;

		assign acc   = {rem_s[k-1], v_s[k-1][sus_pkg::SQ_W-1 -: 2]};
		assign trial = {2'b00, root_s[k-1], 2'b01};
		assign take  = (acc >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			v_s[k]    <= {v_s[k-1][sus_pkg::SQ_W-3:0], 2'b00};
			rem_s[k]  <= take ? sus_pkg::REM_W'(acc - trial) : sus_pkg::REM_W'(acc);
			root_s[k] <= {root_s[k-1][sus_pkg::ROOT_W-2:0], take};
			tag_s[k]  <= tag_s[k-1];
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_tag  = tag_s[N];

endmodule

@@ src/sphere_union_signed_distance.sv @@
// Signed distance to a union of up to 64 spheres plus a probe radius. A clear or an add
// beat leaves the block idle, so it takes the next beat right after. A query reads the
// sphere memory one entry a cycle through a pipelined square-of-differences and
// 25-stage square-root path; with an empty store it goes straight to its result. The
// result waits while the output is stalled, and no new beat is taken while a query runs.
module sphere_union_signed_distance (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [sus_pkg::RAD_W-1:0]               cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [1:0]                              kind,
	input  logic signed [sus_pkg::COORD_W-1:0]      coord_x,
	input  logic signed [sus_pkg::COORD_W-1:0]      coord_y,
	input  logic signed [sus_pkg::COORD_W-1:0]      coord_z,
	input  logic [sus_pkg::RAD_W-1:0]               sphere_radius,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [sus_pkg::DIST_W-1:0]       distance,
	output logic                                    store_empty,
	output logic                                    store_overflow
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_t;

	state_t                             state_q;
	logic [sus_pkg::CNT_W-1:0]          count_q;
	logic                               ovf_q;
	logic [sus_pkg::RAD_W-1:0]          probe_q;
	logic [sus_pkg::ADDR_W-1:0]         rd_idx_q;
	logic                               first_q;
	logic signed [sus_pkg::T_W-1:0]     best_q;
	logic signed [sus_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [sus_pkg::DIST_W-1:0]  res_dist_q;
	logic                               res_empty_q;
	logic                               out_valid_q;
	logic signed [sus_pkg::DIST_W-1:0]  dist_q;
	logic                               empty_q;
	logic                               ovf_out_q;

	logic accept;
	logic wr_en;
	logic rd_last;
	sus_pkg::sphere_t wdata, rdata;

	logic                          vld_s1, last_s1;
	logic                          vld_s2, last_s2;
	logic [sus_pkg::ABS_W-1:0]     ax_s2, ay_s2, az_s2;
	logic [sus_pkg::RAD_W-1:0]     r_s2;
	logic                          vld_s3, last_s3;
	logic [sus_pkg::SQ_W-1:0]      sx_s3, sy_s3, sz_s3;
	logic [sus_pkg::RAD_W-1:0]     r_s3;
	logic                          vld_s4;
	logic [sus_pkg::SQ_W-1:0]      sum_s4;
	sus_pkg::tag_t                 tag_s4;

	logic                          sq_vld;
	logic [sus_pkg::ROOT_W-1:0]    sq_root;
	sus_pkg::tag_t                 sq_tag;

	logic signed [sus_pkg::ABS_W-1:0] dx, dy, dz;
	logic signed [sus_pkg::T_W-1:0]   t_val, new_best, fin;
	logic signed [sus_pkg::DIST_W-1:0] fin_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign wr_en     = accept && (kind == sus_pkg::KIND_ADD) &&
		(count_q < sus_pkg::CNT_W'(sus_pkg::MAX_SPHERES));
	assign wdata     = '{x: coord_x, y: coord_y, z: coord_z, r: sphere_radius};
	assign rd_last   = ({1'b0, rd_idx_q} == (sus_pkg::ADDR_W+1)'(count_q - 1'b1));

	assign out_valid      = out_valid_q;
	assign distance       = dist_q;
	assign store_empty    = empty_q;
	assign store_overflow = ovf_out_q;

	sus_store u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[sus_pkg::ADDR_W-1:0]),
		.wdata (wdata),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign dx = {px_q[sus_pkg::COORD_W-1], px_q} - {rdata.x[sus_pkg::COORD_W-1], rdata.x};
	assign dy = {py_q[sus_pkg::COORD_W-1], py_q} - {rdata.y[sus_pkg::COORD_W-1], rdata.y};
	assign dz = {pz_q[sus_pkg::COORD_W-1], pz_q} - {rdata.z[sus_pkg::COORD_W-1], rdata.z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= rd_last;
		last_s2 <= last_s1;
		ax_s2   <= dx[sus_pkg::ABS_W-1] ? sus_pkg::ABS_W'(-dx) : sus_pkg::ABS_W'(dx);
		ay_s2   <= dy[sus_pkg::ABS_W-1] ? sus_pkg::ABS_W'(-dy) : sus_pkg::ABS_W'(dy);
		az_s2   <= dz[sus_pkg::ABS_W-1] ? sus_pkg::ABS_W'(-dz) : sus_pkg::ABS_W'(dz);
		r_s2    <= rdata.r;
		last_s3 <= last_s2;
		sx_s3   <= ax_s2 * ax_s2;
		sy_s3   <= ay_s2 * ay_s2;
		sz_s3   <= az_s2 * az_s2;
		r_s3    <= r_s2;
		sum_s4  <= sx_s3 + sy_s3 + sz_s3;
		tag_s4  <= '{last: last_s3, radius: r_s3};
	end

	sus_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_sq    (sum_s4),
		.in_tag   (tag_s4),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_tag  (sq_tag)
	);

	assign t_val    = sus_pkg::T_W'({1'b0, sq_tag.radius}) - sus_pkg::T_W'({1'b0, sq_root});
	assign new_best = (first_q || (t_val > best_q)) ? t_val : best_q;
	assign fin      = new_best + sus_pkg::T_W'({1'b0, probe_q});

	always_comb begin
		priority if (fin > sus_pkg::T_W'(sus_pkg::DIST_MAX)) begin
			fin_sat = sus_pkg::DIST_MAX;
		end else if (fin < sus_pkg::T_W'(sus_pkg::DIST_MIN)) begin
			fin_sat = sus_pkg::DIST_MIN;
		end else begin
			fin_sat = sus_pkg::DIST_W'(fin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else if (cfg_we) begin
			probe_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
			pz_q <= coord_z;
		end
		if (sq_vld) begin
			best_q <= new_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			first_q     <= 1'b0;
			res_dist_q  <= '0;
			res_empty_q <= 1'b0;
			out_valid_q <= 1'b0;
			dist_q      <= '0;
			empty_q     <= 1'b0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (sq_vld) begin
				first_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (kind == sus_pkg::KIND_CLEAR) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else if (kind == sus_pkg::KIND_ADD) begin
							if (wr_en) begin
								count_q <= count_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (kind == sus_pkg::KIND_QUERY) begin
							if (count_q == '0) begin
								res_dist_q  <= sus_pkg::DIST_MIN;
								res_empty_q <= 1'b1;
								state_q     <= ST_DONE;
							end else begin
								rd_idx_q <= '0;
								first_q  <= 1'b1;
								state_q  <= ST_RUN;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RUN: begin
					if (rd_last) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (sq_vld && sq_tag.last) begin
						res_dist_q  <= fin_sat;
						res_empty_q <= 1'b0;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						dist_q      <= res_dist_q;
						empty_q     <= res_empty_q;
						ovf_out_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ dv/sphere_union_signed_distance_test.sv @@
module sphere_union_signed_distance_test;
	import sus_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [DIST_W-1:0] sdist;
		logic                     empty;
		logic                     ovf;
	} answer_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [RAD_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                kind;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [RAD_W-1:0]          sphere_radius;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DIST_W-1:0]  distance;
	logic                      store_empty;
	logic                      store_overflow;

	sphere_union_signed_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.sphere_radius(sphere_radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.store_empty(store_empty),
		.store_overflow(store_overflow)
	);

	sphere_t         spheres [MAX_SPHERES];
	int              n_spheres;
	bit              dropped_add;
	logic [RAD_W-1:0] probe;
	answer_t         pending_answers[$];
	int              n_errors;
	int              idle_cycles;
	int              burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 50;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic answer_t sphere_union_distance(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
		answer_t a;
		longint best;
		longint t;
		longint dx;
		longint dy;
		longint dz;
		a.ovf = dropped_add;
		if (n_spheres == 0) begin
			a.sdist = DIST_MIN;
			a.empty = 1'b1;
			return a;
		end
		best = 0;
		for (int i = 0; i < n_spheres; i++) begin
			dx = longint'(px) - longint'(spheres[i].x);
			dy = longint'(py) - longint'(spheres[i].y);
			dz = longint'(pz) - longint'(spheres[i].z);
			t = longint'(spheres[i].r) - longint'(root_floor(dx * dx + dy * dy + dz * dz));
			if (i == 0 || t > best)
				best = t;
		end
		best += longint'(probe);
		if (best > longint'(DIST_MAX))
			best = DIST_MAX;
		if (best < longint'(DIST_MIN))
			best = DIST_MIN;
		a.sdist = best[DIST_W-1:0];
		a.empty = 1'b0;
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	task automatic send_beat(logic [1:0] k, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z, logic [RAD_W-1:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		sphere_radius <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (k)
			KIND_CLEAR: begin
				n_spheres = 0;
				dropped_add = 1'b0;
			end
			KIND_ADD: begin
				if (n_spheres < MAX_SPHERES) begin
					spheres[n_spheres] = '{x: x, y: y, z: z, r: r};
					n_spheres++;
				end else begin
					dropped_add = 1'b1;
				end
			end
			KIND_QUERY: pending_answers.insert(pending_answers.size(),
				sphere_union_distance(x, y, z));
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (MAX_SPHERES + 40) @(posedge clk);
	endtask

	task automatic set_probe(logic [RAD_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		probe = v;
	endtask

	function automatic logic signed [COORD_W-1:0] any_coord();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(COORD_W-1){1'b0}}};
			1: return {1'b0, {(COORD_W-1){1'b1}}};
			2: return COORD_W'($urandom);
			default: return COORD_W'($signed($urandom_range(0, 80000)) - 40000);
		endcase
	endfunction

	function automatic logic [RAD_W-1:0] any_radius();
		case ($urandom_range(0, 4))
			0: return '1;
			1: return '0;
			2: return RAD_W'($urandom);
			default: return RAD_W'($urandom_range(0, 60000));
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [COORD_W-1:0] lo;
		logic signed [COORD_W-1:0] hi;
		lo = {1'b1, {(COORD_W-1){1'b0}}};
		hi = {1'b0, {(COORD_W-1){1'b1}}};
		send_beat(KIND_QUERY, 0, 0, 0, '1);
		send_beat(KIND_ADD, lo, lo, lo, '1);
		send_beat(KIND_QUERY, hi, hi, hi, 0);
		send_beat(KIND_QUERY, lo, lo, lo, 0);
		send_beat(KIND_ADD, hi, hi, hi, 0);
		send_beat(KIND_QUERY, 0, 0, 0, '1);
		send_beat(KIND_UNUSED, hi, lo, hi, '1);
		send_beat(KIND_QUERY, -1, 1, -1, 0);
		send_beat(KIND_CLEAR, hi, hi, hi, '1);
		send_beat(KIND_QUERY, lo, hi, lo, '1);
	endtask

	task automatic test_full_store();
		for (int i = 0; i < MAX_SPHERES + 2; i++)
			send_beat(KIND_ADD, any_coord(), any_coord(), any_coord(), any_radius());
		send_beat(KIND_QUERY, 0, 0, 0, 0);
		send_beat(KIND_QUERY, any_coord(), any_coord(), any_coord(), 0);
		send_beat(KIND_CLEAR, 0, 0, 0, 0);
		send_beat(KIND_QUERY, 0, 0, 0, 0);
	endtask

	task automatic test_random(int n);
		int r;
		int i;
		i = 0;
		while (i < n) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_beat(KIND_CLEAR, any_coord(), any_coord(), any_coord(), any_radius());
			end else if (r < 5) begin
				send_beat(KIND_UNUSED, any_coord(), any_coord(), any_coord(), any_radius());
				continue;
			end else if (r < 55 || n_spheres < 2) begin
				send_beat(KIND_ADD, any_coord(), any_coord(), any_coord(), any_radius());
			end else begin
				send_beat(KIND_QUERY, any_coord(), any_coord(), any_coord(), any_radius());
			end
			i++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected beat", distance, 0);
			end else begin
				if (distance !== pending_answers[0].sdist)
					report_mismatch("distance", distance, pending_answers[0].sdist);
				if (store_empty !== pending_answers[0].empty)
					report_mismatch("store_empty", store_empty, pending_answers[0].empty);
				if (store_overflow !== pending_answers[0].ovf)
					report_mismatch("store_overflow", store_overflow, pending_answers[0].ovf);
				void'(pending_answers.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 2) == 0)
			out_stall <= ($urandom_range(0, 1) == 0);
		else if ($urandom_range(0, 30) == 0)
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("[sphere_union_signed_distance] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_CLEAR;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		sphere_radius = '0;
		out_stall = 1'b0;
		idle_cycles = 0;
		n_errors = 0;
		n_spheres = 0;
		dropped_add = 1'b0;
		probe = '0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		set_probe('1);
		test_extremes();
		test_full_store();
		set_probe(0);
		test_random(500);
		set_probe(RAD_W'($urandom));
		test_random(450);
		set_probe('1);
		test_random(450);
		drain();
		if (n_errors == 0)
			$display("[sphere_union_signed_distance] OK");
		else
			$display("[sphere_union_signed_distance] ERROR");
		$finish;
	end
endmodule
